[design/bent_horns_surface_eval_unit_macros.svh]
// ----------------------------------------------------------------------------
// bent horns surface evaluator: assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BENT_HORNS_SURFACE_EVAL_UNIT_MACROS_SVH
`define BENT_HORNS_SURFACE_EVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BHSE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define BHSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BHSE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define BHSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/bhse_pkg.sv]
// ----------------------------------------------------------------------------
// bhse_pkg
// fixed-point constants and tables for the bent horns surface evaluator
// ----------------------------------------------------------------------------
package bhse_pkg;

  // internal fraction bits of every angle and value
  localparam int DQ = 24;
  localparam int OUT_W = 20;
  localparam int IN_W = 16;
  localparam int CORDIC_ITERS = 20;
  localparam int CW = 28;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 184;

  typedef logic signed [CW-1:0] cq_t;

  localparam longint ONE_Q = 64'd16777216;
  localparam longint PI_Q = 64'd52707179;
  localparam longint TWO_PI_Q = 64'd105414357;
  localparam longint HALF_PI_Q = 64'd26353589;
  localparam longint TWO_PI_3_Q = 64'd35138119;
  localparam longint THIRD_Q = 64'd5592405;
  localparam longint CORDIC_K = 64'd10188014;

  localparam cq_t ONE_C = cq_t'(ONE_Q);
  localparam cq_t TWO_C = cq_t'(2 * ONE_Q);
  localparam cq_t PI_C = cq_t'(PI_Q);
  localparam cq_t HALF_PI_C = cq_t'(HALF_PI_Q);
  localparam cq_t TWO_PI_C = cq_t'(TWO_PI_Q);
  localparam cq_t THIRD_C = cq_t'(THIRD_Q);
  localparam cq_t K_C = cq_t'(CORDIC_K);

  // atan(2^-i) in Q24
  function automatic cq_t atan_q(input int idx);
    case (idx)
      0: return cq_t'(13176795);
      1: return cq_t'(7778716);
      2: return cq_t'(4110060);
      3: return cq_t'(2086331);
      4: return cq_t'(1047214);
      5: return cq_t'(524117);
      6: return cq_t'(262123);
      7: return cq_t'(131069);
      8: return cq_t'(65536);
      9: return cq_t'(32768);
      10: return cq_t'(16384);
      11: return cq_t'(8192);
      12: return cq_t'(4096);
      13: return cq_t'(2048);
      14: return cq_t'(1024);
      15: return cq_t'(512);
      16: return cq_t'(256);
      17: return cq_t'(128);
      18: return cq_t'(64);
      19: return cq_t'(32);
      default: return '0;
    endcase
  endfunction

endpackage

[design/bent_horns_surface_eval_unit.sv]
// ----------------------------------------------------------------------------
// bent_horns_surface_eval_unit
// pipelined evaluation of the bent horns surface point and its u and v
// partial derivatives from one (u, v) pair, four CORDIC lanes in parallel
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)                               tlast tuser
// s_axis   in   u_angle[15:0] v_angle[31:16]                           -     -
// m_axis   out  pos_x pos_y pos_z du_x du_y du_z dv_x dv_y dv_z (20 b) -     -
//
// one pair per cycle while not stalled; the pipeline holds NQ = max(ANGLE_WIDTH -
// FRAC_BITS - 2, 1) steps of the modulo-2pi reduction, then 3 wrap stages,
// 20 CORDIC stages, a sign stage and 4 multiply / round stages
// the pipeline moves as a whole; it freezes while the output register holds
// a result that is not taken, so s_axis_tready follows that register
// reset clears only the valid bits
// ----------------------------------------------------------------------------
`include "bent_horns_surface_eval_unit_macros.svh"

module bent_horns_surface_eval_unit #(
  parameter int FRAC_BITS = 12,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // u_angle, v_angle
  input  logic [bhse_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x, pos_y, pos_z, du_x, du_y, du_z, dv_x, dv_y, dv_z, 4 zero bits
  output logic [bhse_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import bhse_pkg::*;

  localparam int S = DQ - FRAC_BITS;
  localparam int AW = ANGLE_WIDTH;
  localparam int QW = AW + S;
  localparam int NQ = (QW > 26) ? QW - 26 : 1;
  localparam int CWD = ((QW > 27) ? QW : 27) + 1;
  localparam int ND = (AW + 1) / 2;
  localparam int DP = 2 * ND;
  localparam int NS = NQ + 25;
  localparam int VW = QW + 1;
  localparam int BW = ((VW > CW) ? VW : CW) + 1;
  localparam int HW = CW + BW - 24;
  localparam int LW = CW + 25;
  localparam int MW = BW + 5;
  localparam int OW = MW + 1;
  localparam int NL = 9;

  localparam logic [QW-1:0] F1 = QW'((2 ** S) / 3);
  localparam logic [QW-1:0] F2 = QW'((2 ** (S + 1)) / 3);
  localparam logic signed [29:0] PI30 = 30'(PI_Q);
  localparam logic signed [29:0] TP30 = 30'(TWO_PI_Q);
  localparam logic signed [29:0] TP3_30 = 30'(TWO_PI_3_Q);
  localparam logic signed [OW-1:0] RND = OW'(1) <<< (S - 1);
  localparam logic signed [OW-1:0] SAT_HI = OW'(524287);
  localparam logic signed [OW-1:0] SAT_LO = -OW'(524288);

  typedef struct {
    logic           u_neg;
    logic           v_neg;
    logic [CWD-1:0] u_rem;
    logic [CWD-1:0] v_rem;
    cq_t            ang [4];
    logic           fneg [4];
    cq_t            cx [4];
    cq_t            cy [4];
  } stage_t;

  typedef struct {
    logic [DP-1:0]          src;
    logic [DP-1:0]          quo;
    logic [1:0]             rem;
    logic signed [VW-1:0]   vt;
  } div_t;

  logic pipe_en;
  logic [NS-1:0] vld_q;
  logic p1_vld_q, p2_vld_q, p3_vld_q, m_vld_q;
  stage_t st_d [NS];
  stage_t st_q [NS];
  div_t dv_d [NS];
  div_t dv_q [NS];
  logic [AW-1:0] u_a, v_a, u_mag, v_mag;

  cq_t la_d [NL];
  logic signed [BW-1:0] lb_d [NL];
  cq_t la_q [NL];
  logic signed [BW-1:0] lb_q [NL];
  logic signed [HW-1:0] hi_q [NL];
  logic signed [LW-1:0] lo_q [NL];
  logic signed [MW-1:0] sum_q [NL];
  logic [M_TDATA_W-1:0] m_data_d, m_data_q;

  assign pipe_en = !m_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata = m_data_q;

  // low ANGLE_WIDTH bits of the zero-extended field, read as signed
  assign u_a = AW'(32'(s_axis_tdata[IN_W-1:0]));
  assign v_a = AW'(32'(s_axis_tdata[2*IN_W-1:IN_W]));
  assign u_mag = u_a[AW-1] ? (~u_a + AW'(1)) : u_a;
  assign v_mag = v_a[AW-1] ? (~v_a + AW'(1)) : v_a;

  for (genvar gi = 0; gi < NS; gi++) begin : g_stage
    if (gi == 0) begin : g_in
      always_comb begin
        st_d[gi] = st_q[gi];
        st_d[gi].u_neg = u_a[AW-1];
        st_d[gi].v_neg = v_a[AW-1];
        st_d[gi].u_rem = CWD'(u_mag) << S;
        st_d[gi].v_rem = CWD'(v_mag) << S;
      end
    end else if (gi <= NQ) begin : g_red
      // restoring step of |angle| mod 2pi
      localparam logic [CWD-1:0] DK = CWD'(TWO_PI_Q) << (NQ - gi);
      always_comb begin
        st_d[gi] = st_q[gi-1];
        if (st_q[gi-1].u_rem >= DK) begin
          st_d[gi].u_rem = st_q[gi-1].u_rem - DK;
        end
        if (st_q[gi-1].v_rem >= DK) begin
          st_d[gi].v_rem = st_q[gi-1].v_rem - DK;
        end
      end
    end else if (gi == NQ + 1) begin : g_pos
      always_comb begin
        cq_t ru, rv;
        ru = cq_t'({1'b0, st_q[gi-1].u_rem[26:0]});
        rv = cq_t'({1'b0, st_q[gi-1].v_rem[26:0]});
        st_d[gi] = st_q[gi-1];
        // negative angle: move the remainder into [0, 2pi)
        st_d[gi].ang[0] = (st_q[gi-1].u_neg && ru != '0) ? TWO_PI_C - ru : ru;
        st_d[gi].ang[3] = (st_q[gi-1].v_neg && rv != '0) ? TWO_PI_C - rv : rv;
      end
    end else if (gi == NQ + 2) begin : g_wrap
      always_comb begin
        logic signed [29:0] ph [4];
        ph[0] = 30'(st_q[gi-1].ang[0]);
        ph[1] = 30'(st_q[gi-1].ang[0]) + TP3_30;
        ph[2] = 30'(st_q[gi-1].ang[0]) - TP3_30;
        ph[3] = 30'(st_q[gi-1].ang[3]);
        st_d[gi] = st_q[gi-1];
        for (int k = 0; k < 4; k++) begin
          if (ph[k] > PI30) begin
            ph[k] = ph[k] - TP30;
          end else if (ph[k] < -PI30) begin
            ph[k] = ph[k] + TP30;
          end
          st_d[gi].ang[k] = cq_t'(ph[k]);
        end
      end
    end else if (gi == NQ + 3) begin : g_fold
      always_comb begin
        st_d[gi] = st_q[gi-1];
        for (int k = 0; k < 4; k++) begin
          st_d[gi].fneg[k] = 1'b0;
          st_d[gi].cx[k] = K_C;
          st_d[gi].cy[k] = '0;
          if (st_q[gi-1].ang[k] > HALF_PI_C) begin
            st_d[gi].ang[k] = st_q[gi-1].ang[k] - PI_C;
            st_d[gi].fneg[k] = 1'b1;
          end else if (st_q[gi-1].ang[k] < -HALF_PI_C) begin
            st_d[gi].ang[k] = st_q[gi-1].ang[k] + PI_C;
            st_d[gi].fneg[k] = 1'b1;
          end
        end
      end
    end else if (gi < NS - 1) begin : g_cordic
      localparam int J = gi - NQ - 4;
      localparam cq_t ATAN = atan_q(J);
      always_comb begin
        st_d[gi] = st_q[gi-1];
        for (int k = 0; k < 4; k++) begin
          if (!st_q[gi-1].ang[k][CW-1]) begin
            st_d[gi].cx[k] = st_q[gi-1].cx[k] - (st_q[gi-1].cy[k] >>> J);
            st_d[gi].cy[k] = st_q[gi-1].cy[k] + (st_q[gi-1].cx[k] >>> J);
            st_d[gi].ang[k] = st_q[gi-1].ang[k] - ATAN;
          end else begin
            st_d[gi].cx[k] = st_q[gi-1].cx[k] + (st_q[gi-1].cy[k] >>> J);
            st_d[gi].cy[k] = st_q[gi-1].cy[k] - (st_q[gi-1].cx[k] >>> J);
            st_d[gi].ang[k] = st_q[gi-1].ang[k] + ATAN;
          end
        end
      end
    end else begin : g_sign
      always_comb begin
        st_d[gi] = st_q[gi-1];
        for (int k = 0; k < 4; k++) begin
          if (st_q[gi-1].fneg[k]) begin
            st_d[gi].cx[k] = -st_q[gi-1].cx[k];
            st_d[gi].cy[k] = -st_q[gi-1].cy[k];
          end
        end
      end
    end

    // v / 3, two bits of |v| per stage, then scaled to Q24
    if (gi == 0) begin : g_dv_in
      always_comb begin
        dv_d[gi] = dv_q[gi];
        dv_d[gi].src = DP'(v_mag);
        dv_d[gi].quo = '0;
        dv_d[gi].rem = '0;
      end
    end else if (gi <= ND) begin : g_dv_dig
      always_comb begin
        logic [3:0] val;
        val = {dv_q[gi-1].rem, dv_q[gi-1].src[DP-1 -: 2]};
        dv_d[gi] = dv_q[gi-1];
        dv_d[gi].src = dv_q[gi-1].src << 2;
        if (val >= 4'd9) begin
          dv_d[gi].quo = {dv_q[gi-1].quo[DP-3:0], 2'd3};
          dv_d[gi].rem = 2'(val - 4'd9);
        end else if (val >= 4'd6) begin
          dv_d[gi].quo = {dv_q[gi-1].quo[DP-3:0], 2'd2};
          dv_d[gi].rem = 2'(val - 4'd6);
        end else if (val >= 4'd3) begin
          dv_d[gi].quo = {dv_q[gi-1].quo[DP-3:0], 2'd1};
          dv_d[gi].rem = 2'(val - 4'd3);
        end else begin
          dv_d[gi].quo = {dv_q[gi-1].quo[DP-3:0], 2'd0};
          dv_d[gi].rem = val[1:0];
        end
      end
    end else if (gi == NS - 1) begin : g_dv_out
      always_comb begin
        logic [QW-1:0] m3;
        m3 = QW'(dv_q[gi-1].quo[AW-1:0]) << S;
        if (dv_q[gi-1].rem == 2'd1) begin
          m3 = m3 + F1;
        end else if (dv_q[gi-1].rem == 2'd2) begin
          m3 = m3 + F2;
        end
        dv_d[gi] = dv_q[gi-1];
        dv_d[gi].vt = st_q[gi-1].v_neg ? -$signed({1'b0, m3}) : $signed({1'b0, m3});
      end
    end else begin : g_dv_pass
      always_comb begin
        dv_d[gi] = dv_q[gi-1];
      end
    end
  end

  // product operands: lane a is the Q24 factor, lane b the possibly wide one
  always_comb begin
    cq_t fu, fup, fum;
    logic signed [BW-1:0] vtb, svb;
    fu = TWO_C + st_q[NS-1].cx[0];
    fup = TWO_C + st_q[NS-1].cx[1];
    fum = TWO_C + st_q[NS-1].cx[2];
    vtb = BW'(dv_q[NS-1].vt);
    svb = BW'(st_q[NS-1].cy[3]);
    la_d[0] = fu;
    lb_d[0] = vtb - svb;
    la_d[1] = fup;
    lb_d[1] = BW'(st_q[NS-1].cx[3] - ONE_C);
    la_d[2] = fum;
    lb_d[2] = BW'(st_q[NS-1].cx[3] - ONE_C);
    la_d[3] = st_q[NS-1].cy[0];
    lb_d[3] = svb - vtb;
    la_d[4] = st_q[NS-1].cy[1];
    lb_d[4] = BW'(ONE_C - st_q[NS-1].cx[3]);
    la_d[5] = st_q[NS-1].cy[2];
    lb_d[5] = BW'(ONE_C - st_q[NS-1].cx[3]);
    la_d[6] = fu;
    lb_d[6] = BW'(THIRD_C - st_q[NS-1].cx[3]);
    la_d[7] = fup;
    lb_d[7] = -svb;
    la_d[8] = fum;
    lb_d[8] = -svb;
  end

  // round half up to FRAC_BITS, then clamp to the 20-bit range
  always_comb begin
    logic signed [OW-1:0] rr;
    m_data_d = '0;
    for (int k = 0; k < NL; k++) begin
      rr = (OW'(sum_q[k]) + RND) >>> S;
      if (rr > SAT_HI) begin
        rr = SAT_HI;
      end else if (rr < SAT_LO) begin
        rr = SAT_LO;
      end
      m_data_d[k*OUT_W +: OUT_W] = rr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
      p1_vld_q <= vld_q[NS-1];
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      m_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st_q <= st_d;
      dv_q <= dv_d;
      la_q <= la_d;
      lb_q <= lb_d;
      for (int k = 0; k < NL; k++) begin
        // floor(a * b / 2^24) split at bit 24 of b
        hi_q[k] <= la_q[k] * $signed(lb_q[k][BW-1:24]);
        lo_q[k] <= la_q[k] * $signed({1'b0, lb_q[k][23:0]});
        sum_q[k] <= MW'(hi_q[k]) + MW'(lo_q[k] >>> 24);
      end
      m_data_q <= m_data_d;
    end
  end

  `BHSE_ASSERT_NEXT(a_frozen_stall, clk_i, rst_ni, !pipe_en, $stable(vld_q) && $stable(p3_vld_q), "pipeline valids moved during a stall")
  `BHSE_ASSERT_NEXT(a_in_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted pair did not enter the pipeline")
  `BHSE_ASSERT_SAME(a_out_source, clk_i, rst_ni, $rose(m_vld_q), $past(p3_vld_q), "result appeared without a preceding stage")

endmodule

[tb/tb_bent_horns_surface_eval_unit.sv]
// ----------------------------------------------------------------------------
// tb_bent_horns_surface_eval_unit
// streams directed and random (u, v) pairs through the surface evaluator,
// predicts point and partial derivatives in fixed point, checks every field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bent_horns_surface_eval_unit;
  import bhse_pkg::*;

  localparam int NUM_RANDOM = 1150;
  localparam int STALL_LIMIT = 5000;

  class surface_scoreboard;
    logic [OUT_W*9-1:0] pending[$];
    int errors = 0;

    static function longint quad_angle(logic [IN_W-1:0] raw);
      longint a;
      a = longint'(signed'(raw));
      return a * (64'sd1 << (DQ - 12));
    endfunction

    static function void cordic(longint ang, output longint c, output longint s);
      longint r, x, y, dx, dy;
      bit neg;
      r = ang % TWO_PI_Q;
      x = CORDIC_K;
      y = 0;
      neg = 0;
      if (r > PI_Q) r -= TWO_PI_Q;
      else if (r < -PI_Q) r += TWO_PI_Q;
      if (r > HALF_PI_Q) begin
        r -= PI_Q;
        neg = 1;
      end else if (r < -HALF_PI_Q) begin
        r += PI_Q;
        neg = 1;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x -= dx;
          y += dy;
          r -= longint'(atan_q(i));
        end else begin
          x += dx;
          y -= dy;
          r += longint'(atan_q(i));
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    // product in Q24, floor, then round half up and saturate to the output field
    static function logic [OUT_W-1:0] fixed_out(longint a, longint b);
      longint q, r;
      q = (a * b) >>> DQ;
      r = (q + (64'sd1 << (DQ - 13))) >>> (DQ - 12);
      if (r > 524287) r = 524287;
      if (r < -524288) r = -524288;
      return r[OUT_W-1:0];
    endfunction

    function void note_pair(logic [IN_W-1:0] u_raw, logic [IN_W-1:0] v_raw);
      longint u, v, cu, su, cup, sup, cum, sum, cv, sv, vt, fu, fup, fum;
      logic [OUT_W*9-1:0] r;
      u = quad_angle(u_raw);
      v = quad_angle(v_raw);
      cordic(u, cu, su);
      cordic(u + TWO_PI_3_Q, cup, sup);
      cordic(u - TWO_PI_3_Q, cum, sum);
      cordic(v, cv, sv);
      vt = v / 3;
      fu = 2 * ONE_Q + cu;
      fup = 2 * ONE_Q + cup;
      fum = 2 * ONE_Q + cum;
      r[0*OUT_W +: OUT_W] = fixed_out(fu, vt - sv);
      r[1*OUT_W +: OUT_W] = fixed_out(fup, cv - ONE_Q);
      r[2*OUT_W +: OUT_W] = fixed_out(fum, cv - ONE_Q);
      r[3*OUT_W +: OUT_W] = fixed_out(su, sv - vt);
      r[4*OUT_W +: OUT_W] = fixed_out(sup, ONE_Q - cv);
      r[5*OUT_W +: OUT_W] = fixed_out(sum, ONE_Q - cv);
      r[6*OUT_W +: OUT_W] = fixed_out(fu, THIRD_Q - cv);
      r[7*OUT_W +: OUT_W] = fixed_out(fup, -sv);
      r[8*OUT_W +: OUT_W] = fixed_out(fum, -sv);
      pending.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
      string names[9] = '{"pos_x", "pos_y", "pos_z", "du_x", "du_y", "du_z",
                          "dv_x", "dv_y", "dv_z"};
      logic [OUT_W*9-1:0] exp_r;
      if (pending.size() == 0) begin
        $error("result transfer with no expected result");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int f = 0; f < 9; f++) begin
        if (data[f*OUT_W +: OUT_W] !== exp_r[f*OUT_W +: OUT_W]) begin
          $error("%s: expected %0d, got %0d", names[f],
                 signed'(exp_r[f*OUT_W +: OUT_W]), signed'(data[f*OUT_W +: OUT_W]));
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  surface_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  bent_horns_surface_eval_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // transfers at the edge, observed with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pair(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** bent_horns_surface_eval_unit: FAILED **");
      $finish;
    end
  end

  // receiver: mode rotates between free flow, random and heavy stall
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(1, 0) == 1);
      default: m_axis_tready <= ($urandom_range(5, 0) == 0);
    endcase
  end

  task automatic send_pair(input logic [15:0] u, input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, u};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // the wait comes before the test of the queue, so the last transfer is noted before the check
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(12868, 0) - 6434);   // about -pi/2 .. pi/2
      2: return 16'($urandom_range(51472, 0) - 25736);  // about -2pi .. 2pi
      default: return 16'($urandom_range(1000, 0) - 500);
    endcase
  endfunction

  initial begin
    logic [15:0] corners[12] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001,
                                 16'd6434, -16'sd6434, 16'd12868, -16'sd12868,
                                 16'd25736, 16'd3217, 16'd8579};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // corner angles: extremes, +-pi, +-pi/2, 2pi, pi/4, 2pi/3
    for (int i = 0; i < 12; i++)
      send_pair(corners[i], corners[(i * 5 + 3) % 12]);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h0000, 16'h7fff);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'haaaa, 16'h5555);
    send_pair(16'h5555, 16'haaaa);
    drain();
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_pair(rand_angle(), rand_angle());
      if (n == NUM_RANDOM / 2) drain();
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0)
      $display("** bent_horns_surface_eval_unit: PASSED **");
    else
      $display("** bent_horns_surface_eval_unit: FAILED **");
    $finish;
  end

endmodule

[bent_horns_surface_eval_unit.f]
+incdir+design
design/bhse_pkg.sv
design/bent_horns_surface_eval_unit.sv
tb/tb_bent_horns_surface_eval_unit.sv
